[design/spa_pkg.sv]
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, command and status codes, and cell operations for the
// segment placement allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int CFG_W            = 17;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_MEM_SIZE = 1'b1;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE
  } cell_op_t;

endpackage

[design/spa_cell.sv]
// ----------------------------------------------------------------------------
// spa_cell
// One table slot. Holds a segment base and length; shifts right on insert,
// left on delete, and takes a new base on a compaction write.
// ----------------------------------------------------------------------------
module spa_cell import spa_pkg::*; #(
  parameter int IDX       = 0,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int CW        = 5,
  parameter int IW        = 4
) (
  input  logic                 clk,
  input  cell_op_t             op,
  input  logic [CW-1:0]        count,
  input  logic [IW-1:0]        widx,
  input  logic [ADDR_BITS-1:0] key,
  input  logic [ADDR_BITS:0]   new_len,
  input  logic [ADDR_BITS-1:0] left_base,
  input  logic [ADDR_BITS:0]   left_len,
  input  logic [ADDR_BITS-1:0] right_base,
  input  logic [ADDR_BITS:0]   right_len,
  input  logic                 chain_in,
  output logic                 chain_out,
  output logic [ADDR_BITS-1:0] base_r,
  output logic [ADDR_BITS:0]   len_r
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic                 valid;
  logic                 ins;
  logic                 hit;
  logic [ADDR_BITS-1:0] base_nxt;
  logic [ADDR_BITS:0]   len_nxt;

  assign valid = MY_IDX < count;

  // Chain flags: insert point and delete point ripple along the row
  always_comb begin
    ins       = (valid && base_r > key) || (MY_IDX == count);
    hit       = chain_in || (valid && base_r == key);
    chain_out = 1'b0;
    base_nxt  = base_r;
    len_nxt   = len_r;
    case (op)
      CELL_INSERT: begin
        chain_out = ins;
        if (ins) begin
          if (chain_in) begin
            base_nxt = left_base;
            len_nxt  = left_len;
          end else begin
            base_nxt = key;
            len_nxt  = new_len;
          end
        end
      end
      CELL_DELETE: begin
        chain_out = hit;
        if (hit) begin
          base_nxt = right_base;
          len_nxt  = right_len;
        end
      end
      CELL_WRITE: begin
        if (widx == MY_IDX[IW-1:0] && valid) base_nxt = key;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    len_r  <= len_nxt;
  end

endmodule

[design/segment_placement_allocator.sv]
// ----------------------------------------------------------------------------
// segment_placement_allocator
// Sorted segment table in a row of cells with first/best fit placement and
// compaction that reports each moved segment.
// ----------------------------------------------------------------------------
// Allocate scans the table in S_FIT (first fit stops at the first gap that fits),
// inserts in S_INS and may compact once and rescan; free runs S_DEL, compact
// runs S_CPT; a full table or a zero size answers straight from S_IDLE.
// One item at a time: busy stays high while the sequencer walks the table one
// cell per cycle. Results appear at most one per cycle on out_valid; no stall.
// Reset (synchronous, rst_n low) empties the table, sets first fit and 65536.
module segment_placement_allocator import spa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [ADDR_BITS:0]   in_seg_size,
  input  logic [ADDR_BITS-1:0] in_seg_base,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [ADDR_BITS-1:0] out_placed_base,
  output logic                 out_is_move,
  output logic [ADDR_BITS-1:0] out_move_from,
  output logic [ADDR_BITS-1:0] out_move_to,
  output logic [ADDR_BITS:0]   out_move_length,
  output logic                 out_last
);

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int SW = ((ADDR_BITS > CFG_W) ? ADDR_BITS : CFG_W) + 2;
  localparam logic [SW-1:0] CAP = SW'(1) << ADDR_BITS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  typedef enum logic [2:0] {S_IDLE, S_FIT, S_CPT, S_INS, S_DEL} state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        idx_r;
  logic                 fit_mode_r;
  logic [CFG_W-1:0]     mem_size_r;
  logic [1:0]           cmd_r;
  logic [ADDR_BITS:0]   size_r;
  logic [ADDR_BITS-1:0] key_r;
  logic [SW-1:0]        prev_r;
  logic                 found_r;
  logic [SW-1:0]        best_at_r;
  logic [SW-1:0]        best_left_r;
  logic                 compacted_r;
  logic [ADDR_BITS-1:0] where_r;

  logic                 ov_r;
  logic [1:0]           os_r;
  logic [ADDR_BITS-1:0] opb_r;
  logic                 om_r;
  logic [ADDR_BITS-1:0] of_r;
  logic [ADDR_BITS-1:0] ot_r;
  logic [ADDR_BITS:0]   ol_r;
  logic                 olast_r;

  cell_op_t             op;
  logic [ADDR_BITS-1:0] key;
  logic [ADDR_BITS-1:0] cb   [MAX_SEGMENTS];
  logic [ADDR_BITS:0]   cl   [MAX_SEGMENTS];
  logic                 chn  [MAX_SEGMENTS+1];

  logic [SW-1:0]        mem_eff;
  logic [SW-1:0]        b;
  logic [SW-1:0]        e;
  logic [SW-1:0]        sz;
  logic                 fits;
  logic [SW-1:0]        left;
  logic [SW-1:0]        nxt_base;

  // Cell row
  assign chn[0] = 1'b0;
  for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
    spa_cell #(.IDX(j), .ADDR_BITS(ADDR_BITS), .CW(CW), .IW(IW)) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count_r),
      .widx      (idx_r[IW-1:0]),
      .key       (key),
      .new_len   (size_r),
      .left_base ((j > 0) ? cb[(j > 0) ? j-1 : 0] : cb[0]),
      .left_len  ((j > 0) ? cl[(j > 0) ? j-1 : 0] : cl[0]),
      .right_base(cb[(j < MAX_SEGMENTS-1) ? j+1 : j]),
      .right_len (cl[(j < MAX_SEGMENTS-1) ? j+1 : j]),
      .chain_in  (chn[j]),
      .chain_out (chn[j+1]),
      .base_r    (cb[j]),
      .len_r     (cl[j])
    );
  end

  // Scan read and fit arithmetic
  always_comb begin
    mem_eff  = (SW'(mem_size_r) > CAP) ? CAP : SW'(mem_size_r);
    b        = SW'(cb[idx_r[IW-1:0]]);
    e        = b + SW'(cl[idx_r[IW-1:0]]);
    sz       = SW'(size_r);
    fits     = (b > prev_r) && (b - prev_r >= sz) && (prev_r + sz <= mem_eff);
    left     = b - prev_r - sz;
    nxt_base = SW'(prev_r[ADDR_BITS-1:0]);
  end

  // Cell commands
  always_comb begin
    op  = CELL_NOP;
    key = key_r;
    case (state_r)
      S_INS: begin
        op  = CELL_INSERT;
        key = where_r;
      end
      S_DEL: op = CELL_DELETE;
      S_CPT: begin
        op  = (idx_r < count_r && b != prev_r) ? CELL_WRITE : CELL_NOP;
        key = prev_r[ADDR_BITS-1:0];
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_placed_base = opb_r;
  assign out_is_move     = om_r;
  assign out_move_from   = of_r;
  assign out_move_to     = ot_r;
  assign out_move_length = ol_r;
  assign out_last        = olast_r;

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    ov_r    <= 1'b0;
    os_r    <= ST_OK;
    opb_r   <= '0;
    om_r    <= 1'b0;
    of_r    <= '0;
    ot_r    <= '0;
    ol_r    <= '0;
    olast_r <= 1'b0;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      fit_mode_r <= 1'b0;
      mem_size_r <= CFG_W'(65536);
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FIT_MODE) fit_mode_r <= cfg_data[0];
        else mem_size_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r       <= in_cmd;
            size_r      <= in_seg_size;
            key_r       <= in_seg_base;
            idx_r       <= '0;
            prev_r      <= '0;
            found_r     <= 1'b0;
            compacted_r <= 1'b0;
            case (in_cmd)
              CMD_ALLOC: begin
                if (count_r >= MAX_CNT) begin
                  ov_r <= 1'b1; os_r <= ST_FULL; olast_r <= 1'b1;
                end else if (in_seg_size == '0) begin
                  ov_r <= 1'b1; os_r <= ST_NO_SPACE; olast_r <= 1'b1;
                end else begin
                  state_r <= S_FIT;
                end
              end
              CMD_FREE:    state_r <= S_DEL;
              CMD_COMPACT: state_r <= S_CPT;
              default: ;
            endcase
          end
        end
        S_FIT: begin
          if (idx_r < count_r) begin
            if (fits && !fit_mode_r) begin
              where_r <= prev_r[ADDR_BITS-1:0];
              state_r <= S_INS;
            end else begin
              if (fits && (!found_r || left < best_left_r)) begin
                found_r     <= 1'b1;
                best_left_r <= left;
                best_at_r   <= prev_r;
              end
              if (e > prev_r) prev_r <= e;
              idx_r <= idx_r + 1'b1;
            end
          end else if (found_r) begin
            where_r <= best_at_r[ADDR_BITS-1:0];
            state_r <= S_INS;
          end else if (prev_r + sz <= mem_eff) begin
            where_r <= prev_r[ADDR_BITS-1:0];
            state_r <= S_INS;
          end else if (!compacted_r) begin
            compacted_r <= 1'b1;
            idx_r       <= '0;
            prev_r      <= '0;
            state_r     <= S_CPT;
          end else begin
            ov_r <= 1'b1; os_r <= ST_NO_SPACE; olast_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_CPT: begin
          if (idx_r < count_r) begin
            if (b != prev_r) begin
              ov_r <= 1'b1;
              om_r <= 1'b1;
              of_r <= b[ADDR_BITS-1:0];
              ot_r <= prev_r[ADDR_BITS-1:0];
              ol_r <= cl[idx_r[IW-1:0]];
              prev_r <= nxt_base + SW'(cl[idx_r[IW-1:0]]);
            end else begin
              prev_r <= e;
            end
            idx_r <= idx_r + 1'b1;
          end else if (cmd_r == CMD_ALLOC) begin
            idx_r   <= '0;
            prev_r  <= '0;
            found_r <= 1'b0;
            state_r <= S_FIT;
          end else begin
            ov_r <= 1'b1; os_r <= ST_OK; olast_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_INS: begin
          count_r <= count_r + 1'b1;
          ov_r    <= 1'b1;
          os_r    <= ST_OK;
          opb_r   <= where_r;
          olast_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_DEL: begin
          ov_r    <= 1'b1;
          olast_r <= 1'b1;
          if (chn[MAX_SEGMENTS]) begin
            count_r <= count_r - 1'b1;
            os_r    <= ST_OK;
          end else begin
            os_r <= ST_NOT_FND;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT) else $error("entry count above table depth");
  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && om_r) |-> (busy && !olast_r)) else $error("move outside compaction");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1 ||
      count_r == $past(count_r) - 1'b1)) else $error("count jumped");
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> (ov_r && olast_r && !busy)) else $error("insert not closed");

endmodule
